>>> src/ttag_pkg.sv
`default_nettype none

package ttag_pkg;

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 11;
    localparam int RANK_REG_W    = 3;
    localparam int EXT_REG_W     = 11;
    localparam int ORDER_REG_W   = 8;
    localparam int NUM_EXT_REGS  = 4;
    localparam int ORDER_FIELD_W = 2;
    localparam int ELEM_W        = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANK  = 3'd0,
        REG_EXT0  = 3'd1,
        REG_EXT1  = 3'd2,
        REG_EXT2  = 3'd3,
        REG_EXT3  = 3'd4,
        REG_ORDER = 3'd5
    } t_cfg_reg;

    localparam logic [RANK_REG_W-1:0]  RANK_RESET  = 3'd1;
    localparam logic [EXT_REG_W-1:0]   EXT_RESET   = 11'd1;
    localparam logic [ORDER_REG_W-1:0] ORDER_RESET = 8'd228;

    typedef struct packed {
        logic ready;
        logic restart;
    } t_cfg_ctrl;

endpackage

`default_nettype wire

>>> src/ttag_cfg.sv
`default_nettype none

module ttag_cfg #(
    parameter int MAX_RANK    = 4,
    parameter int EXTENT_BITS = 10,
    parameter int ADDR_BITS   = 20,
    parameter int RANK_W      = 3
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_cfg_we,
    input  wire logic [ttag_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [ttag_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    output ttag_pkg::t_cfg_ctrl                          o_ctrl,
    output logic [RANK_W-1:0]                            o_rank,
    output logic [MAX_RANK-1:0][EXTENT_BITS-1:0]         o_emax,
    output logic [MAX_RANK-1:0][ADDR_BITS-1:0]           o_delta
);
    import ttag_pkg::*;

    localparam int IW    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int EXT_W = EXTENT_BITS + 1;

    typedef enum logic [3:0] {
        S_STRIDE = 4'b0001,
        S_WRAP   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_READY  = 4'b1000
    } t_seq_state;

    logic [RANK_REG_W-1:0]                     r_rank;
    logic [NUM_EXT_REGS-1:0][EXT_REG_W-1:0]    r_ext;
    logic [ORDER_REG_W-1:0]                    r_order;

    t_seq_state                                r_state;
    logic [IW-1:0]                             r_cnt;
    logic [ADDR_BITS-1:0]                      r_s;
    logic [MAX_RANK-1:0][ADDR_BITS-1:0]        r_stride;
    logic [MAX_RANK-1:0][ADDR_BITS-1:0]        r_delta;
    logic [ADDR_BITS-1:0]                      r_suffix;
    logic [ADDR_BITS-1:0]                      r_prod;
    logic [ADDR_BITS-1:0]                      r_pstride;
    logic                                      r_pv;
    logic [IW-1:0]                             r_pa;

    logic                                      cfg_hit;
    logic                                      restart;
    logic [RANK_W-1:0]                         rr;
    logic [NUM_EXT_REGS-1:0][EXT_W-1:0]        ext_e;
    logic [ORDER_REG_W-1:0]                    ord_sh;
    logic [ORDER_FIELD_W-1:0]                  ord_a;
    logic                                      st_active;
    logic                                      a_ok;
    logic [EXT_W-1:0]                          ext_sel;
    logic [ADDR_BITS+EXT_W-1:0]                s_mul;
    logic [ADDR_BITS-1:0]                      stride_sel;
    logic [EXTENT_BITS-1:0]                    emax_sel;
    logic [ADDR_BITS+EXTENT_BITS-1:0]          wb_mul;

    function automatic logic [EXT_W-1:0] ext_eff(input logic [EXT_REG_W-1:0] v);
        logic [31:0] e;
        e = {{(32-EXT_REG_W){1'b0}}, v};
        if (e == 32'd0) e = 32'd1;
        if (e > (32'd1 << EXTENT_BITS)) e = 32'd1 << EXTENT_BITS;
        return e[EXT_W-1:0];
    endfunction

    assign cfg_hit = i_cfg_we && (i_cfg_idx <= REG_ORDER);
    assign restart = !i_rst_n || cfg_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank  <= RANK_RESET;
            r_ext   <= {NUM_EXT_REGS{EXT_RESET}};
            r_order <= ORDER_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_RANK:  r_rank   <= i_cfg_data[RANK_REG_W-1:0];
                REG_EXT0:  r_ext[0] <= i_cfg_data[EXT_REG_W-1:0];
                REG_EXT1:  r_ext[1] <= i_cfg_data[EXT_REG_W-1:0];
                REG_EXT2:  r_ext[2] <= i_cfg_data[EXT_REG_W-1:0];
                REG_EXT3:  r_ext[3] <= i_cfg_data[EXT_REG_W-1:0];
                REG_ORDER: r_order  <= i_cfg_data[ORDER_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        int rk;
        rk = int'(r_rank);
        if (rk < 1) rk = 1;
        if (rk > MAX_RANK) rk = MAX_RANK;
        rr = RANK_W'(rk);
    end

    always_comb begin
        for (int i = 0; i < NUM_EXT_REGS; i++) ext_e[i] = ext_eff(r_ext[i]);
    end

    // per-axis last position; axes without a register have extent 1
    for (genvar a = 0; a < MAX_RANK; a++) begin : g_emax
        if (a < NUM_EXT_REGS) begin : g_reg
            logic [EXT_W-1:0] emax_full;
            assign emax_full = ext_e[a] - {{EXTENT_BITS{1'b0}}, 1'b1};
            assign o_emax[a] = emax_full[EXTENT_BITS-1:0];
        end else begin : g_one
            assign o_emax[a] = '0;
        end
    end

    // stride pass: destination positions from innermost outward
    assign ord_sh    = r_order >> {r_cnt, 1'b0};
    assign ord_a     = ord_sh[ORDER_FIELD_W-1:0];
    assign st_active = int'(r_cnt) < int'(rr);
    assign a_ok      = int'(ord_a) < int'(rr);
    assign ext_sel   = ext_e[ord_a];
    assign s_mul     = {{EXT_W{1'b0}}, r_s} * {{ADDR_BITS{1'b0}}, ext_sel};

    // wrap pass: amount an axis takes back when it rolls over
    assign stride_sel = r_stride[r_cnt];
    assign emax_sel   = o_emax[r_cnt];
    assign wb_mul     = {{EXTENT_BITS{1'b0}}, stride_sel} * {{ADDR_BITS{1'b0}}, emax_sel};

    always_ff @(posedge i_clk) begin
        if (restart) begin
            r_state  <= S_STRIDE;
            r_cnt    <= IW'(MAX_RANK - 1);
            r_s      <= {{(ADDR_BITS-1){1'b0}}, 1'b1};
            r_stride <= '0;
            r_suffix <= '0;
            r_pv     <= 1'b0;
        end else begin
            if (r_pv) begin
                r_delta[r_pa] <= r_pstride - r_suffix;
                r_suffix      <= r_suffix + r_prod;
            end
            case (r_state)
                S_STRIDE: begin
                    if (st_active) begin
                        for (int i = 0; i < MAX_RANK; i++) begin
                            if (a_ok && int'(ord_a) == i) r_stride[i] <= r_stride[i] + r_s;
                        end
                        r_s <= s_mul[ADDR_BITS-1:0];
                    end
                    if (r_cnt == '0) begin
                        r_state <= S_WRAP;
                        r_cnt   <= IW'(MAX_RANK - 1);
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_WRAP: begin
                    r_prod    <= wb_mul[ADDR_BITS-1:0];
                    r_pstride <= stride_sel;
                    r_pv      <= 1'b1;
                    r_pa      <= r_cnt;
                    if (r_cnt == '0) r_state <= S_DRAIN;
                    else r_cnt <= r_cnt - 1'b1;
                end
                S_DRAIN: begin
                    r_pv    <= 1'b0;
                    r_state <= S_READY;
                end
                S_READY: ;
                default: r_state <= S_STRIDE;
            endcase
        end
    end

    assign o_ctrl.ready   = (r_state == S_READY);
    assign o_ctrl.restart = cfg_hit;
    assign o_rank         = rr;
    assign o_delta        = r_delta;

`ifndef SYNTHESIS
    a_ready_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READY) |-> !r_pv)
        else $error("delta pass still pending while ready");
    a_write_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> (r_state == S_STRIDE) && (r_cnt == IW'(MAX_RANK - 1)))
        else $error("register write did not restart stride pass");
    a_drain_to_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) && !cfg_hit |=> (r_state == S_READY))
        else $error("drain did not end in ready");
`endif

endmodule

`default_nettype wire

>>> src/ttag_odom.sv
`default_nettype none

module ttag_odom #(
    parameter int MAX_RANK    = 4,
    parameter int EXTENT_BITS = 10,
    parameter int ADDR_BITS   = 20,
    parameter int RANK_W      = 3
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  ttag_pkg::t_cfg_ctrl                          i_ctrl,
    input  wire logic [RANK_W-1:0]                       i_rank,
    input  wire logic [MAX_RANK-1:0][EXTENT_BITS-1:0]    i_emax,
    input  wire logic [MAX_RANK-1:0][ADDR_BITS-1:0]      i_delta,
    input  wire logic                                    i_in_valid,
    output logic                                         o_in_ready,
    input  wire logic [ttag_pkg::ELEM_W-1:0]             i_element_bits,
    output logic                                         o_out_valid,
    input  wire logic                                    i_out_ready,
    output logic [ADDR_BITS-1:0]                         o_dest_address,
    output logic [ttag_pkg::ELEM_W-1:0]                  o_element_out,
    output logic                                         o_last_element
);
    import ttag_pkg::*;

    logic                                  r_in_vld;
    logic [ELEM_W-1:0]                     r_in_elem;
    logic                                  r_out_vld;
    logic [ADDR_BITS-1:0]                  r_out_addr;
    logic [ELEM_W-1:0]                     r_out_elem;
    logic                                  r_out_last;
    logic [MAX_RANK-1:0][EXTENT_BITS-1:0]  r_pos;
    logic [ADDR_BITS-1:0]                  r_addr;

    logic [MAX_RANK-1:0][EXTENT_BITS-1:0]  n_pos;
    logic [ADDR_BITS-1:0]                  n_addr;
    logic                                  found;
    logic                                  adv;
    logic                                  acc;

    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = i_rst_n && i_ctrl.ready && (!r_in_vld || adv);
    assign acc        = i_in_valid && o_in_ready;

    // innermost axis that has not reached its end takes the step
    always_comb begin
        found  = 1'b0;
        n_pos  = r_pos;
        n_addr = r_addr;
        for (int a = MAX_RANK - 1; a >= 0; a--) begin
            if (a < int'(i_rank) && !found) begin
                if (r_pos[a] == i_emax[a]) begin
                    n_pos[a] = '0;
                end else begin
                    n_pos[a] = r_pos[a] + 1'b1;
                    n_addr   = r_addr + i_delta[a];
                    found    = 1'b1;
                end
            end
        end
        if (!found) n_addr = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_pos     <= '0;
            r_addr    <= '0;
        end else begin
            if (i_ctrl.restart) begin
                r_pos  <= '0;
                r_addr <= '0;
            end else if (adv) begin
                r_pos  <= n_pos;
                r_addr <= n_addr;
            end
            if (acc) r_in_vld <= 1'b1;
            else if (adv) r_in_vld <= 1'b0;
            if (adv) r_out_vld <= 1'b1;
            else if (i_out_ready) r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_in_elem <= i_element_bits;
        if (adv) begin
            r_out_addr <= r_addr;
            r_out_elem <= r_in_elem;
            r_out_last <= !found;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_dest_address = r_out_addr;
    assign o_element_out  = r_out_elem;
    assign o_last_element = r_out_last;

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !found |=> (r_addr == '0) && (r_pos == '0))
        else $error("traversal not cleared after final word");
    a_no_accept_in_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctrl.ready |-> !o_in_ready)
        else $error("word accepted during stride setup");
    a_step_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !i_ctrl.restart |=> r_out_vld && (r_out_addr == $past(r_addr)))
        else $error("result register missed a step");
`endif

endmodule

`default_nettype wire

>>> src/tensor_transpose_address_gen.sv
`default_nettype none

// Axis-permute address generator: elements of a row-major tensor enter in source order, one
// word per clock, and each leaves with its row-major address in the permuted tensor, the
// element bits unchanged, and a flag on the tensor's final element. An element passes through
// two registers (input register, then result register), and a new one is taken every cycle
// while the output keeps up. Each position step is a single add of a per-axis address delta
// chosen by the innermost axis that has not reached its end. Those deltas come from a setup
// pass that runs after reset and after every register write: a stride pass and a wrap pass,
// one multiply per cycle, then a drain step; no element is taken until it ends. Any register
// write also restarts the traversal at the first element.
module tensor_transpose_address_gen #(
    parameter int MAX_RANK    = 4,
    parameter int EXTENT_BITS = 10,
    parameter int ADDR_BITS   = 20
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [ttag_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [ttag_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [ttag_pkg::ELEM_W-1:0]         i_element_bits,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [ADDR_BITS-1:0]                     o_dest_address,
    output logic [ttag_pkg::ELEM_W-1:0]              o_element_out,
    output logic                                     o_last_element
);
    import ttag_pkg::*;

    localparam int RANK_W = $clog2(MAX_RANK + 1);

    t_cfg_ctrl                             ctrl;
    logic [RANK_W-1:0]                     rank;
    logic [MAX_RANK-1:0][EXTENT_BITS-1:0]  emax;
    logic [MAX_RANK-1:0][ADDR_BITS-1:0]    delta;

    ttag_cfg #(
        .MAX_RANK    (MAX_RANK),
        .EXTENT_BITS (EXTENT_BITS),
        .ADDR_BITS   (ADDR_BITS),
        .RANK_W      (RANK_W)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_ctrl     (ctrl),
        .o_rank     (rank),
        .o_emax     (emax),
        .o_delta    (delta)
    );

    ttag_odom #(
        .MAX_RANK    (MAX_RANK),
        .EXTENT_BITS (EXTENT_BITS),
        .ADDR_BITS   (ADDR_BITS),
        .RANK_W      (RANK_W)
    ) u_odom (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_rank         (rank),
        .i_emax         (emax),
        .i_delta        (delta),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_element_bits (i_element_bits),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_dest_address (o_dest_address),
        .o_element_out  (o_element_out),
        .o_last_element (o_last_element)
    );

endmodule

`default_nettype wire
